// ----- src/splt_pkg.sv -----
// Package for the sorted price level table: payload structs, action and status codes,
// the controller state type and default sizes.
`default_nettype none
package splt_pkg;
    localparam int TABLE_DEPTH_DEF = 256;
    localparam int TOPN_MAX_DEF    = 64;

    typedef enum logic [2:0] {
        ACT_ADD   = 3'd0,
        ACT_DEL   = 3'd1,
        ACT_GET   = 3'd2,
        ACT_FIRST = 3'd3,
        ACT_TOPN  = 3'd4
    } t_action;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] price;
        logic [31:0] amount;
        logic [6:0]  count;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] level_price;
        logic [31:0] level_amount;
        logic [39:0] total_amount;
        logic        last;
    } t_rsp;

    typedef enum logic [3:0] {
        S_IDLE, S_SRCH, S_SWAIT, S_HIT, S_UP_RD, S_UP_WR, S_DN_RD, S_DN_WR,
        S_TOPN, S_TWAIT, S_RESP
    } t_state;
endpackage
`default_nettype wire

// ----- src/sorted_price_level_table_top.sv -----
// Sorted price level table, depends on splt_pkg. Levels sit in one synchronous memory
// sorted by price. Get, delete and add run a lower bound search of k probes, each a
// memory read and a compare, k = ceil(log2(levels+1)) <= log2(TABLE_DEPTH)+1; a get,
// an update or a failed add shows its result when the search ends. An insert moves
// each level above the new slot up with one read and one write, then writes the new
// level; a removal moves each level above the freed slot down the same way. First and
// top-n read one level and then show it as a result, level by level; an empty run or
// an unused action answers in the next cycle. Each result is a single-cycle strobe on
// o_valid and the receiver cannot stall. busy is high from the cycle after the accepting
// edge through the cycle that shows the last result of the transaction.
`default_nettype none
module sorted_price_level_table_top
    import splt_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int TOPN_MAX    = TOPN_MAX_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire t_req i_req,
    output logic      o_valid,
    output t_rsp      o_rsp
);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic [63:0] r_mem [TABLE_DEPTH];
    logic [63:0] r_rd;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [63:0]   wr_data;
    logic          wr_en;

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= wr_data;
        r_rd <= r_mem[rd_addr];
    end

    t_state r_st, n_st;
    t_req   r_req, n_req;
    logic [CW-1:0] r_cnt, n_cnt, r_lo, n_lo, r_hi, n_hi, r_i, n_i;
    logic [6:0]    r_n, n_n;
    logic [39:0]   r_tot, n_tot;
    logic          r_ov, n_ov;
    t_rsp          r_rsp, n_rsp;
    logic [CW-1:0] mid;

    assign mid = CW'(({1'b0, r_lo} + {1'b0, r_hi}) >> 1);
    assign busy = (r_st != S_IDLE);
    assign o_valid = r_ov;
    assign o_rsp = r_rsp;

    function automatic t_rsp mk_rsp(logic [1:0] st, logic [31:0] p, logic [31:0] a,
                                    logic [39:0] tot, logic fin);
        t_rsp r;
        r.status = st;
        r.level_price = p;
        r.level_amount = a;
        r.total_amount = tot;
        r.last = fin;
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_cnt <= '0; r_tot <= '0; r_ov <= 1'b0;
        end else begin
            r_st <= n_st; r_cnt <= n_cnt; r_tot <= n_tot; r_ov <= n_ov;
        end
        r_req <= n_req; r_lo <= n_lo; r_hi <= n_hi; r_i <= n_i; r_n <= n_n;
        r_rsp <= n_rsp;
    end

    always_comb begin
        logic [6:0] top_n;
        logic       hit;
        logic       fin;
        top_n = (i_req.count > 7'(TOPN_MAX)) ? 7'(TOPN_MAX) : i_req.count;
        if (int'(top_n) > int'(r_cnt)) top_n = 7'(r_cnt);
        if (i_req.action == ACT_FIRST) top_n = (r_cnt != '0) ? 7'd1 : 7'd0;
        hit = (r_lo < r_cnt) && (r_rd[63:32] == r_req.price);
        fin = (int'(r_i) + 1 == int'(r_n));
        n_st = r_st; n_req = r_req; n_cnt = r_cnt; n_lo = r_lo; n_hi = r_hi;
        n_i = r_i; n_n = r_n; n_tot = r_tot; n_ov = 1'b0; n_rsp = r_rsp;
        rd_addr = AW'(r_lo); wr_en = 1'b0; wr_addr = AW'(r_i); wr_data = '0;
        unique case (r_st)
            S_IDLE: begin
                if (start) begin
                    n_req = i_req; n_lo = '0; n_hi = r_cnt; n_i = '0; n_n = top_n;
                    priority if (i_req.action == ACT_FIRST || i_req.action == ACT_TOPN) begin
                        if (top_n == '0) begin
                            n_ov = 1'b1;
                            n_rsp = mk_rsp((r_cnt == '0) ? ST_NOTFOUND : ST_OK, '0, '0,
                                           r_tot, 1'b1);
                            n_st = S_RESP;
                        end else n_st = S_TOPN;
                    end else if (i_req.action <= ACT_GET) begin
                        n_st = S_SRCH;
                    end else begin
                        n_ov = 1'b1;
                        n_rsp = mk_rsp(ST_NOTFOUND, '0, '0, r_tot, 1'b1);
                        n_st = S_RESP;
                    end
                end
            end
            S_SRCH: begin
                // lower bound search; at the end read the candidate slot
                rd_addr = (r_lo < r_hi) ? AW'(mid) : AW'(r_lo);
                n_st = (r_lo < r_hi) ? S_SWAIT : S_HIT;
            end
            S_SWAIT: begin
                if (r_rd[63:32] < r_req.price) n_lo = mid + CW'(1);
                else n_hi = mid;
                n_st = S_SRCH;
            end
            S_HIT: begin
                n_rsp = mk_rsp(ST_OK, '0, '0, r_tot, 1'b1);
                n_st = S_RESP;
                unique case (r_req.action)
                    ACT_GET: begin
                        if (hit) n_rsp = mk_rsp(ST_OK, r_rd[63:32], r_rd[31:0], r_tot, 1'b1);
                        else n_rsp.status = ST_NOTFOUND;
                    end
                    ACT_DEL: begin
                        if (hit) begin
                            n_tot = r_tot - {8'd0, r_rd[31:0]}; n_i = r_lo;
                            n_st = S_DN_RD;
                        end else n_rsp.status = ST_NOTFOUND;
                    end
                    default: begin
                        if (hit) begin
                            if (r_req.amount == '0) begin
                                n_tot = r_tot - {8'd0, r_rd[31:0]}; n_i = r_lo;
                                n_st = S_DN_RD;
                            end else begin
                                n_tot = r_tot - {8'd0, r_rd[31:0]} + {8'd0, r_req.amount};
                                wr_en = 1'b1; wr_addr = AW'(r_lo);
                                wr_data = {r_req.price, r_req.amount};
                            end
                        end else if (r_req.amount == '0) n_rsp.status = ST_NOTFOUND;
                        else if (r_cnt >= CW'(TABLE_DEPTH)) n_rsp.status = ST_FULL;
                        else begin
                            n_tot = r_tot + {8'd0, r_req.amount}; n_i = r_cnt;
                            n_st = S_UP_RD;
                        end
                    end
                endcase
                n_rsp.total_amount = n_tot;
                n_ov = (n_st == S_RESP);
            end
            S_UP_RD: begin
                // r_i is the slot to fill from r_i-1
                if (r_i > r_lo) begin
                    rd_addr = AW'(r_i - CW'(1));
                    n_st = S_UP_WR;
                end else begin
                    wr_en = 1'b1; wr_addr = AW'(r_lo);
                    wr_data = {r_req.price, r_req.amount};
                    n_cnt = r_cnt + CW'(1);
                    n_ov = 1'b1; n_rsp = mk_rsp(ST_OK, '0, '0, r_tot, 1'b1);
                    n_st = S_RESP;
                end
            end
            S_UP_WR: begin
                wr_en = 1'b1; wr_addr = AW'(r_i); wr_data = r_rd;
                n_i = r_i - CW'(1);
                n_st = S_UP_RD;
            end
            S_DN_RD: begin
                // r_i is the slot to fill from r_i+1
                if (r_i + CW'(1) < r_cnt) begin
                    rd_addr = AW'(r_i + CW'(1));
                    n_st = S_DN_WR;
                end else begin
                    n_cnt = r_cnt - CW'(1);
                    n_ov = 1'b1; n_rsp = mk_rsp(ST_OK, '0, '0, r_tot, 1'b1);
                    n_st = S_RESP;
                end
            end
            S_DN_WR: begin
                wr_en = 1'b1; wr_addr = AW'(r_i); wr_data = r_rd;
                n_i = r_i + CW'(1);
                n_st = S_DN_RD;
            end
            S_TOPN: begin
                rd_addr = AW'(r_i);
                n_st = S_TWAIT;
            end
            S_TWAIT: begin
                n_ov = 1'b1;
                n_rsp = mk_rsp(ST_OK, r_rd[63:32], r_rd[31:0], r_tot, fin);
                if (fin) n_st = S_RESP;
                else begin
                    n_i = r_i + CW'(1);
                    n_st = S_TOPN;
                end
            end
            S_RESP: begin
                n_st = S_IDLE;
            end
        endcase
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) o_valid |-> busy)
        else $error("result without transaction");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt <= CW'(TABLE_DEPTH))
        else $error("level count overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("busy not raised");
endmodule
`default_nettype wire

// ----- test/tb_sorted_price_level_table_top.sv -----
// Testbench for sorted_price_level_table_top: directed and random action streams
// checked against a behavioral table model kept in the bench. Depends on splt_pkg.
`default_nettype none
module tb_sorted_price_level_table_top;
    import splt_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = TABLE_DEPTH_DEF;
    localparam int TOPN  = TOPN_MAX_DEF;
    localparam logic [2:0] ACT_RSVD_LO = 3'd5;
    localparam logic [2:0] ACT_RSVD_HI = 3'd7;
    localparam logic [31:0] PRICE_BASE = 32'd1000;
    localparam logic [31:0] PRICE_STEP = 32'd7;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_req i_req = '0;
    logic o_valid;
    t_rsp o_rsp;

    sorted_price_level_table_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_req(i_req), .o_valid(o_valid), .o_rsp(o_rsp)
    );

    always #5 i_clk = ~i_clk;

    // Book model
    logic [31:0] book_price [DEPTH];
    logic [31:0] book_amount [DEPTH];
    int          book_levels = 0;
    logic [39:0] book_total = '0;
    t_rsp        expected_rsp [$];
    int          mismatches = 0;
    bit          idle_en = 1'b1;

    function automatic t_rsp mk_rsp(logic [1:0] st, logic [31:0] p, logic [31:0] a,
                                    logic fin);
        t_rsp r;
        r.status = st;
        r.level_price = p;
        r.level_amount = a;
        r.total_amount = book_total;
        r.last = fin;
        return r;
    endfunction

    function automatic void exp_add(t_rsp r);
        expected_rsp.insert(expected_rsp.size(), r);
    endfunction

    // Lower bound search: first slot whose price is not below key.
    function automatic int book_find(logic [31:0] key, output bit hit);
        int pos;
        pos = 0;
        while (pos < book_levels && book_price[pos] < key) pos++;
        hit = (pos < book_levels) && (book_price[pos] == key);
        return pos;
    endfunction

    function automatic void book_remove(int pos);
        book_total = book_total - {8'd0, book_amount[pos]};
        for (int i = pos; i + 1 < book_levels; i++) begin
            book_price[i] = book_price[i + 1];
            book_amount[i] = book_amount[i + 1];
        end
        book_levels--;
    endfunction

    function automatic void book_apply(t_req r);
        bit hit;
        int pos;
        int n;
        case (r.action)
            ACT_ADD: begin
                pos = book_find(r.price, hit);
                if (hit) begin
                    if (r.amount == 0) book_remove(pos);
                    else begin
                        book_total = book_total - {8'd0, book_amount[pos]}
                                     + {8'd0, r.amount};
                        book_amount[pos] = r.amount;
                    end
                    exp_add(mk_rsp(ST_OK, '0, '0, 1'b1));
                end else if (r.amount == 0) begin
                    exp_add(mk_rsp(ST_NOTFOUND, '0, '0, 1'b1));
                end else if (book_levels >= DEPTH) begin
                    exp_add(mk_rsp(ST_FULL, '0, '0, 1'b1));
                end else begin
                    for (int i = book_levels; i > pos; i--) begin
                        book_price[i] = book_price[i - 1];
                        book_amount[i] = book_amount[i - 1];
                    end
                    book_price[pos] = r.price;
                    book_amount[pos] = r.amount;
                    book_levels++;
                    book_total = book_total + {8'd0, r.amount};
                    exp_add(mk_rsp(ST_OK, '0, '0, 1'b1));
                end
            end
            ACT_DEL: begin
                pos = book_find(r.price, hit);
                if (hit) book_remove(pos);
                exp_add(mk_rsp(hit ? ST_OK : ST_NOTFOUND, '0, '0, 1'b1));
            end
            ACT_GET: begin
                pos = book_find(r.price, hit);
                if (hit)
                    exp_add(mk_rsp(ST_OK, book_price[pos], book_amount[pos], 1'b1));
                else
                    exp_add(mk_rsp(ST_NOTFOUND, '0, '0, 1'b1));
            end
            ACT_FIRST: begin
                if (book_levels > 0)
                    exp_add(mk_rsp(ST_OK, book_price[0], book_amount[0], 1'b1));
                else
                    exp_add(mk_rsp(ST_NOTFOUND, '0, '0, 1'b1));
            end
            ACT_TOPN: begin
                n = r.count;
                if (n > TOPN) n = TOPN;
                if (n > book_levels) n = book_levels;
                if (n == 0)
                    exp_add(mk_rsp(book_levels == 0 ? ST_NOTFOUND : ST_OK, '0, '0, 1'b1));
                for (int i = 0; i < n; i++)
                    exp_add(mk_rsp(ST_OK, book_price[i], book_amount[i], i + 1 == n));
            end
            default: exp_add(mk_rsp(ST_NOTFOUND, '0, '0, 1'b1));
        endcase
    endfunction

    // Called at a rising edge; leaves start high after the transaction is taken.
    task automatic send_req(logic [2:0] act, logic [31:0] p, logic [31:0] a,
                            logic [6:0] cnt);
        t_req r;
        r.action = act;
        r.price = p;
        r.amount = a;
        r.count = cnt;
        if (idle_en && $urandom_range(0, 99) < 6) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        // taken at the first edge that sees busy low
        do @(posedge i_clk); while (busy);
        book_apply(r);
    endtask

    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_valid) begin
            if (expected_rsp.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", o_rsp);
            end else begin
                want = expected_rsp.pop_front();
                if (o_rsp !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p got %p", want, o_rsp);
                end
            end
        end
    end

    task automatic test_empty_and_basic();
        send_req(ACT_FIRST, '0, '0, '0);
        send_req(ACT_TOPN, '0, '0, 7'd5);
        send_req(ACT_GET, 32'd55, '0, '0);
        send_req(ACT_DEL, 32'd55, '0, '0);
        send_req(ACT_ADD, 32'd55, '0, '0);
        send_req(ACT_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);
        send_req(ACT_ADD, 32'd0, 32'd1, '0);
        send_req(ACT_ADD, 32'd500, 32'hAAAA_5555, '0);
        send_req(ACT_ADD, 32'd500, 32'h5555_AAAA, '0);
        send_req(ACT_GET, 32'd500, '0, '0);
        send_req(ACT_GET, 32'hFFFF_FFFF, '0, '0);
        send_req(ACT_FIRST, '0, '0, '0);
        send_req(ACT_TOPN, '0, '0, 7'd0);
        send_req(ACT_TOPN, '0, '0, 7'd127);
        send_req(ACT_TOPN, '0, '0, 7'd2);
        send_req(ACT_ADD, 32'd0, 32'd0, '0);
        send_req(ACT_DEL, 32'd500, '0, '0);
        send_req(ACT_GET, 32'd500, '0, '0);
        for (int k = int'(ACT_RSVD_LO); k <= int'(ACT_RSVD_HI); k++)
            send_req(3'(k), 32'd500, 32'd9, 7'd3);
    endtask

    task automatic test_full_table();
        logic [31:0] p;
        // Clear, then fill in ascending order so no levels move.
        while (book_levels > 0) send_req(ACT_DEL, book_price[book_levels - 1], '0, '0);
        idle_en = 1'b0;
        for (int i = 0; i < DEPTH; i++)
            send_req(ACT_ADD, PRICE_BASE + PRICE_STEP * 32'(i), $urandom() | 32'd1, '0);
        idle_en = 1'b1;
        send_req(ACT_ADD, 32'd3, 32'd10, '0);
        send_req(ACT_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);
        p = PRICE_BASE + PRICE_STEP * 10;
        send_req(ACT_ADD, p, 32'hFFFF_FFFF, '0);
        send_req(ACT_TOPN, '0, '0, 7'd127);
        send_req(ACT_TOPN, '0, '0, 7'd64);
        send_req(ACT_ADD, p, 32'd0, '0);
        send_req(ACT_ADD, 32'd3, 32'd10, '0);
        send_req(ACT_FIRST, '0, '0, '0);
    endtask

    task automatic test_random_mix(int items);
        int sel;
        logic [31:0] p;
        logic [31:0] a;
        for (int i = 0; i < items; i++) begin
            sel = $urandom_range(0, 99);
            p = ($urandom_range(0, 9) == 0) ? $urandom()
                : PRICE_BASE + PRICE_STEP * $urandom_range(0, 300);
            case ($urandom_range(0, 3))
                0: a = '0;
                1: a = $urandom();
                2: a = 32'hFFFF_FFFF - $urandom_range(0, 3);
                default: a = $urandom_range(1, 1000);
            endcase
            if (sel < 45)      send_req(ACT_ADD, p, a, 7'($urandom()));
            else if (sel < 70) send_req(ACT_DEL, p, a, 7'($urandom()));
            else if (sel < 83) send_req(ACT_GET, p, a, 7'($urandom()));
            else if (sel < 87) send_req(ACT_FIRST, p, a, 7'($urandom()));
            else if (sel < 96)
                send_req(ACT_TOPN, p, a, 7'($urandom_range(0, 3) == 0 ?
                                            $urandom() : $urandom_range(0, 6)));
            else send_req(3'($urandom_range(ACT_RSVD_LO, ACT_RSVD_HI)), p, a, 7'($urandom()));
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_and_basic();
        test_full_table();
        test_random_mix(40);
        start <= 1'b0;
        while (expected_rsp.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (mismatches == 0 && expected_rsp.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
`default_nettype wire
